### src/rcss_pkg.sv
// Shared types and constants for the RC stick superexpo shaper.
// Used by rcss_axis_pipe, rc_superexpo_shaper_unit and the testbench; depends on nothing else.
package rcss_pkg;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_EXPO_ROLL   = 3'd0,
        REG_EXPO_PITCH  = 3'd1,
        REG_EXPO_YAW    = 3'd2,
        REG_SUPER_ROLL  = 3'd3,
        REG_SUPER_PITCH = 3'd4,
        REG_SUPER_YAW   = 3'd5
    } reg_idx_t;

    // Fixed-point limits
    localparam logic [14:0] AXIS_LIMIT  = 15'd32735;
    localparam logic [14:0] EXPO_LIMIT  = 15'd32440;
    localparam logic [15:0] SUPER_LIMIT = 16'd32768;
    localparam logic [15:0] ONE_Q15     = 16'd32768;

    // Datapath widths
    localparam int MAG_W  = 15;    // clamped stick magnitude
    localparam int PROD_W = 30;    // products of two Q1.15 magnitudes
    localparam int CUBE_W = 60;    // e * a^3
    localparam int X_W    = 31;    // expo value, units 2^-30
    localparam int NUM_W  = 48;    // divider dividend
    localparam int DIV_W  = 32;    // divider divisor
    localparam int QW     = 16;    // quotient bits, one per divider stage

    localparam logic [X_W-1:0] ONE_Q30 = 31'h4000_0000;

    // Pipeline layout: six stages ahead of the divider (the last one sets up the
    // dividend), QW divider stages, one output stage.
    localparam int DIV_FIRST = 6;
    localparam int OUT_STG   = DIV_FIRST + QW;
    localparam int NSTG      = OUT_STG + 1;

    typedef struct packed {
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic signed [15:0] yaw_in;
        logic signed [15:0] thrust_in;
    } in_t;

    typedef struct packed {
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] yaw_out;
        logic        [14:0] thrust_out;
    } out_t;

    function automatic logic [14:0] clamp_expo(input logic [15:0] raw);
        clamp_expo = (raw > 16'(EXPO_LIMIT)) ? EXPO_LIMIT : raw[14:0];
    endfunction

    function automatic logic [15:0] clamp_super(input logic [15:0] raw);
        clamp_super = (raw > SUPER_LIMIT) ? SUPER_LIMIT : raw;
    endfunction

endpackage

### src/rcss_axis_pipe.sv
// Pipelined expo/superexpo curve for one stick axis: multiplies, then a
// one-bit-per-stage restoring divider. Depends on rcss_pkg.
module rcss_axis_pipe (
    input  logic                      aclk,
    input  logic [rcss_pkg::NSTG-1:0] stage_en,
    input  logic signed [15:0]        raw_in,
    input  logic [14:0]               expo_lim,
    input  logic [15:0]               super_lim,
    output logic signed [15:0]        shaped
);

    // Stage 0: sign and clamped magnitude.
    logic [15:0]                 abs_in;
    logic [rcss_pkg::MAG_W-1:0]  a_next;
    logic [rcss_pkg::MAG_W-1:0]  a_reg;
    logic                        neg_reg [0:rcss_pkg::OUT_STG-1];

    assign abs_in = raw_in[15] ? 16'(~raw_in + 16'd1) : raw_in;
    assign a_next = (abs_in > 16'(rcss_pkg::AXIS_LIMIT)) ? rcss_pkg::AXIS_LIMIT
                                                          : abs_in[14:0];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            a_reg      <= a_next;
            neg_reg[0] <= raw_in[15];
        end
    end

    // Sign travels alongside the data through every stage.
    for (genvar k = 1; k < rcss_pkg::OUT_STG; k++) begin : g_sign
        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Stage 1: partial products.
    logic [rcss_pkg::PROD_W-1:0] aa_reg, ea_reg, cea_reg, ag_reg;
    logic [15:0]                 e_comp;

    assign e_comp = 16'(rcss_pkg::ONE_Q15 - 16'(expo_lim));

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            aa_reg  <= rcss_pkg::PROD_W'(a_reg) * rcss_pkg::PROD_W'(a_reg);
            ea_reg  <= rcss_pkg::PROD_W'(expo_lim) * rcss_pkg::PROD_W'(a_reg);
            cea_reg <= rcss_pkg::PROD_W'(e_comp) * rcss_pkg::PROD_W'(a_reg);
            ag_reg  <= rcss_pkg::PROD_W'(super_lim) * rcss_pkg::PROD_W'(a_reg);
        end
    end

    // Stage 2: e * a^3.
    logic [rcss_pkg::CUBE_W-1:0] ea3_reg;
    logic [rcss_pkg::PROD_W-1:0] cea2_reg, ag2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            ea3_reg  <= rcss_pkg::CUBE_W'(ea_reg) * rcss_pkg::CUBE_W'(aa_reg);
            cea2_reg <= cea_reg;
            ag2_reg  <= ag_reg;
        end
    end

    // Stage 3: rounded expo value and superexpo denominator.
    // The linear term is a whole multiple of 2^30, so only the cubic term rounds.
    logic [rcss_pkg::CUBE_W:0] ea3_rnd;
    logic [rcss_pkg::X_W-1:0]  x_reg, d_reg;

    assign ea3_rnd = (rcss_pkg::CUBE_W+1)'(ea3_reg) + ((rcss_pkg::CUBE_W+1)'(1) << 29);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            x_reg <= rcss_pkg::X_W'(ea3_rnd >> 30) + rcss_pkg::X_W'(cea2_reg);
            d_reg <= rcss_pkg::ONE_Q30 - rcss_pkg::X_W'(ag2_reg);
        end
    end

    // Stage 4: numerator x * (1 - g).
    logic [15:0]                g_comp;
    logic [rcss_pkg::NUM_W-2:0] num_reg;
    logic [rcss_pkg::X_W-1:0]   d2_reg;

    assign g_comp = 16'(rcss_pkg::ONE_Q15 - super_lim);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            num_reg <= (rcss_pkg::NUM_W-1)'(x_reg) * (rcss_pkg::NUM_W-1)'(g_comp);
            d2_reg  <= d_reg;
        end
    end

    // Stage 5: round-half-up division set up as (2*num + d) / (2*d).
    logic [rcss_pkg::NUM_W-1:0] rem_reg [0:rcss_pkg::QW];
    logic [rcss_pkg::DIV_W-1:0] div_reg [0:rcss_pkg::QW];
    logic [rcss_pkg::QW-1:0]    q_reg   [0:rcss_pkg::QW];

    always_ff @(posedge aclk) begin
        if (stage_en[rcss_pkg::DIV_FIRST-1]) begin
            rem_reg[0] <= {num_reg, 1'b0} + rcss_pkg::NUM_W'(d2_reg);
            div_reg[0] <= {d2_reg, 1'b0};
            q_reg[0]   <= '0;
        end
    end

    // Divider stages, quotient MSB first.
    for (genvar j = 0; j < rcss_pkg::QW; j++) begin : g_div
        logic [rcss_pkg::NUM_W-1:0] trial;
        logic                       fits;

        assign trial = rcss_pkg::NUM_W'(div_reg[j]) << (rcss_pkg::QW - 1 - j);
        assign fits  = (rem_reg[j] >= trial);

        always_ff @(posedge aclk) begin
            if (stage_en[rcss_pkg::DIV_FIRST + j]) begin
                rem_reg[j+1] <= fits ? (rem_reg[j] - trial) : rem_reg[j];
                div_reg[j+1] <= div_reg[j];
                q_reg[j+1]   <= {q_reg[j][rcss_pkg::QW-2:0], fits};
            end
        end
    end

    // Clamp and restore the sign; the caller registers this.
    logic [rcss_pkg::QW-1:0] mag;
    logic [15:0]             mag_c;

    assign mag    = q_reg[rcss_pkg::QW];
    assign mag_c  = (mag > 16'(rcss_pkg::AXIS_LIMIT)) ? 16'(rcss_pkg::AXIS_LIMIT) : mag;
    assign shaped = neg_reg[rcss_pkg::OUT_STG-1] ? $signed(16'(16'd0 - mag_c))
                                                 : $signed(mag_c);

endmodule

### src/rc_superexpo_shaper_unit.sv
// Top level of the RC stick superexpo shaper: APB register file, stall
// control and the three axis pipelines. Depends on rcss_pkg and rcss_axis_pipe.
//
// One stick command (roll, pitch, yaw, thrust) goes in per transfer and one
// shaped command comes out per transfer, in order. The block takes a new
// command every cycle unless a stalled output has filled every stage; each
// result passes through the 16-stage divider that forms expo*(1-g)/(1-|v|g),
// one quotient bit per stage. Each pipeline stage holds while the stage after
// it is full and stalled, so empty stages keep filling while a result waits.
// The user must write the six curve registers over APB while no command is in
// flight; the block does not enforce it. They read back as written, and values beyond range are clamped where used.
module rc_superexpo_shaper_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcss_pkg::ADDR_W-1:0] paddr,
    input  logic [rcss_pkg::DATA_W-1:0] pwdata,
    output logic [rcss_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rcss_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rcss_pkg::out_t              m_data
);

    // Configuration registers
    logic [15:0] expo_roll_reg, expo_pitch_reg, expo_yaw_reg;
    logic [15:0] super_roll_reg, super_pitch_reg, super_yaw_reg;
    rcss_pkg::reg_idx_t reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = rcss_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expo_roll_reg   <= '0;
            expo_pitch_reg  <= '0;
            expo_yaw_reg    <= '0;
            super_roll_reg  <= '0;
            super_pitch_reg <= '0;
            super_yaw_reg   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                rcss_pkg::REG_EXPO_ROLL:   expo_roll_reg   <= pwdata[15:0];
                rcss_pkg::REG_EXPO_PITCH:  expo_pitch_reg  <= pwdata[15:0];
                rcss_pkg::REG_EXPO_YAW:    expo_yaw_reg    <= pwdata[15:0];
                rcss_pkg::REG_SUPER_ROLL:  super_roll_reg  <= pwdata[15:0];
                rcss_pkg::REG_SUPER_PITCH: super_pitch_reg <= pwdata[15:0];
                rcss_pkg::REG_SUPER_YAW:   super_yaw_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rcss_pkg::REG_EXPO_ROLL:   prdata = {16'd0, expo_roll_reg};
            rcss_pkg::REG_EXPO_PITCH:  prdata = {16'd0, expo_pitch_reg};
            rcss_pkg::REG_EXPO_YAW:    prdata = {16'd0, expo_yaw_reg};
            rcss_pkg::REG_SUPER_ROLL:  prdata = {16'd0, super_roll_reg};
            rcss_pkg::REG_SUPER_PITCH: prdata = {16'd0, super_pitch_reg};
            rcss_pkg::REG_SUPER_YAW:   prdata = {16'd0, super_yaw_reg};
            default:                   prdata = '0;
        endcase
    end

    // Stage valid bits and per-stage load enables. A stage loads when it is
    // empty or its content moves on in the same cycle.
    logic [rcss_pkg::NSTG-1:0] v_reg;
    logic [rcss_pkg::NSTG-1:0] stage_en;

    always_comb begin
        stage_en[rcss_pkg::OUT_STG] = !v_reg[rcss_pkg::OUT_STG] || m_ready;
        for (int k = rcss_pkg::OUT_STG - 1; k >= 0; k--) begin
            stage_en[k] = !v_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = v_reg[rcss_pkg::OUT_STG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < rcss_pkg::NSTG; k++) begin
                if (stage_en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Axis pipelines
    logic signed [15:0] roll_shaped, pitch_shaped, yaw_shaped;

    rcss_axis_pipe u_roll (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .raw_in    (s_data.roll_in),
        .expo_lim  (rcss_pkg::clamp_expo(expo_roll_reg)),
        .super_lim (rcss_pkg::clamp_super(super_roll_reg)),
        .shaped    (roll_shaped)
    );

    rcss_axis_pipe u_pitch (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .raw_in    (s_data.pitch_in),
        .expo_lim  (rcss_pkg::clamp_expo(expo_pitch_reg)),
        .super_lim (rcss_pkg::clamp_super(super_pitch_reg)),
        .shaped    (pitch_shaped)
    );

    rcss_axis_pipe u_yaw (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .raw_in    (s_data.yaw_in),
        .expo_lim  (rcss_pkg::clamp_expo(expo_yaw_reg)),
        .super_lim (rcss_pkg::clamp_super(super_yaw_reg)),
        .shaped    (yaw_shaped)
    );

    // Thrust saturates on entry and rides along with the axes.
    logic [14:0] thr_next;
    logic [14:0] thr_reg [0:rcss_pkg::OUT_STG-1];

    assign thr_next = s_data.thrust_in[15] ? 15'd0 : s_data.thrust_in[14:0];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            thr_reg[0] <= thr_next;
        end
        for (int k = 1; k < rcss_pkg::OUT_STG; k++) begin
            if (stage_en[k]) begin
                thr_reg[k] <= thr_reg[k-1];
            end
        end
    end

    // Output register
    rcss_pkg::out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[rcss_pkg::OUT_STG]) begin
            m_data_reg.roll_out   <= roll_shaped;
            m_data_reg.pitch_out  <= pitch_shaped;
            m_data_reg.yaw_out    <= yaw_shaped;
            m_data_reg.thrust_out <= thr_reg[rcss_pkg::OUT_STG-1];
        end
    end

    assign m_data = m_data_reg;

`ifndef SYNTHESIS
    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg))
        else $error("input refused while a pipeline stage is empty");

    // An accepted command occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted command lost at pipeline entry");

    // Shaped axes never leave the clamped range.
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.roll_out  >= -16'sd32735 && m_data.roll_out  <= 16'sd32735 &&
                     m_data.pitch_out >= -16'sd32735 && m_data.pitch_out <= 16'sd32735 &&
                     m_data.yaw_out   >= -16'sd32735 && m_data.yaw_out   <= 16'sd32735))
        else $error("shaped axis outside +/-32735");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for rc_superexpo_shaper_unit: stick commands go in over a
// valid/ready channel, curve registers are set over APB, and every shaped command is
// checked against a fixed-point model of the expo/superexpo curve. Depends on rcss_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_REGS          = 6;
    localparam int SPARE_REG_FIRST = 6;
    localparam int SPARE_REG_LAST  = 7;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 55;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [rcss_pkg::ADDR_W-1:0] paddr = '0;
    logic [rcss_pkg::DATA_W-1:0] pwdata = '0;
    logic [rcss_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    logic           s_valid = 1'b0;
    logic           s_ready;
    rcss_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    rcss_pkg::out_t m_data;

    // Shadow copy of the curve registers, indexed by register number.
    logic [15:0] cfg_regs [N_REGS];

    rcss_pkg::in_t  cmd_q[$];
    rcss_pkg::out_t shaped_q[$];
    int   items_queued = 0;
    int   items_accepted = 0;
    int   mismatches = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    logic s_taken = 1'b0;
    logic quiet_tail = 1'b0;

    rc_superexpo_shaper_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Shapes one stick axis. The curve is odd, so the clamped magnitude is shaped
    // and the sign put back afterwards; both roundings are half up on the magnitude.
    function automatic logic signed [15:0] shape_stick(input logic signed [15:0] raw,
                                                       input logic [15:0] e_raw,
                                                       input logic [15:0] g_raw);
        int                sv;
        longint unsigned   a, e, g, n, x, d, q;
        logic [15:0]       mag16;
        sv = raw;
        a = (sv < 0) ? longint'(-sv) : longint'(sv);
        if (a > rcss_pkg::AXIS_LIMIT)
            a = rcss_pkg::AXIS_LIMIT;
        e = (e_raw > rcss_pkg::EXPO_LIMIT) ? longint'(rcss_pkg::EXPO_LIMIT)
                                           : longint'(e_raw);
        g = (g_raw > rcss_pkg::SUPER_LIMIT) ? longint'(rcss_pkg::SUPER_LIMIT)
                                            : longint'(g_raw);
        n = (((longint'(rcss_pkg::ONE_Q15) - e) * a) << 30) + e * a * a * a;
        x = (n + (64'd1 << 29)) >> 30;
        d = (64'd1 << 30) - a * g;
        q = (2 * x * (longint'(rcss_pkg::ONE_Q15) - g) + d) / (2 * d);
        if (q > rcss_pkg::AXIS_LIMIT)
            q = rcss_pkg::AXIS_LIMIT;
        mag16 = q[15:0];
        return (sv < 0) ? -mag16 : mag16;
    endfunction

    function automatic rcss_pkg::out_t shape_command(input rcss_pkg::in_t cmd);
        rcss_pkg::out_t res;
        res.roll_out  = shape_stick(cmd.roll_in,  cfg_regs[rcss_pkg::REG_EXPO_ROLL],
                                    cfg_regs[rcss_pkg::REG_SUPER_ROLL]);
        res.pitch_out = shape_stick(cmd.pitch_in, cfg_regs[rcss_pkg::REG_EXPO_PITCH],
                                    cfg_regs[rcss_pkg::REG_SUPER_PITCH]);
        res.yaw_out   = shape_stick(cmd.yaw_in,   cfg_regs[rcss_pkg::REG_EXPO_YAW],
                                    cfg_regs[rcss_pkg::REG_SUPER_YAW]);
        res.thrust_out = cmd.thrust_in[15] ? 15'd0 : cmd.thrust_in[14:0];
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Sender: a held command stays put until its transfer; otherwise random idle
    // bursts are mixed in except during the quiet tail of the run.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            s_valid <= 1'b1;
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (cmd_q.size() != 0 && !quiet_tail && $urandom_range(3) == 0) begin
            send_gap <= $urandom_range(6);
            s_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
            s_valid <= 1'b1;
            s_data <= cmd_q.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, which stop during the quiet tail.
    always @(negedge aclk) begin
        if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(4) == 0) begin
            stall_left <= $urandom_range(6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rcss_pkg::out_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                shaped_q.push_back(shape_command(s_data));
                items_accepted++;
            end
            if (m_valid && m_ready) begin
                if (shaped_q.size() == 0) begin
                    note_mismatch("result transfer with no command outstanding");
                end else begin
                    want = shaped_q.pop_front();
                    if (m_data.roll_out !== want.roll_out)
                        note_mismatch($sformatf("roll_out expected %0d, got %0d",
                                                want.roll_out, m_data.roll_out));
                    if (m_data.pitch_out !== want.pitch_out)
                        note_mismatch($sformatf("pitch_out expected %0d, got %0d",
                                                want.pitch_out, m_data.pitch_out));
                    if (m_data.yaw_out !== want.yaw_out)
                        note_mismatch($sformatf("yaw_out expected %0d, got %0d",
                                                want.yaw_out, m_data.yaw_out));
                    if (m_data.thrust_out !== want.thrust_out)
                        note_mismatch($sformatf("thrust_out expected %0d, got %0d",
                                                want.thrust_out, m_data.thrust_out));
                end
            end
        end
    end

    task automatic apb_write(input int idx, input logic [15:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rcss_pkg::ADDR_W'(4 * idx);
        pwdata <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= rcss_pkg::REG_SUPER_YAW)
            cfg_regs[idx] = value;
    endtask

    function automatic logic [15:0] pick_cfg_value();
        case ($urandom_range(6))
            0: return 16'd0;
            1: return 16'(rcss_pkg::EXPO_LIMIT);
            2: return 16'(rcss_pkg::EXPO_LIMIT) + 16'd1;
            3: return rcss_pkg::ONE_Q15;
            4: return 16'hFFFF;
            5: return 16'($urandom_range(32768));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_stick();
        case ($urandom_range(4))
            0: return 16'(32767 - $urandom_range(80));
            1: return 16'(-32768 + $urandom_range(80));
            2: return 16'($urandom_range(2000) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_command(input rcss_pkg::in_t cmd);
        cmd_q.push_back(cmd);
        items_queued++;
    endtask

    // Axis values around the clamp bound and zero; thrust around both saturation ends.
    task automatic queue_directed();
        logic [15:0]   axis_pts [12];
        logic [15:0]   thr_pts [6];
        rcss_pkg::in_t cmd;
        axis_pts = '{16'h8000, 16'h8001, -16'sd32736, -16'sd32735, -16'sd32734, 16'hFFFF,
                     16'd0, 16'd1, 16'd32734, 16'd32735, 16'd32736, 16'd32767};
        thr_pts = '{16'h8000, 16'hFFFF, 16'd0, 16'd1, 16'd32766, 16'd32767};
        for (int k = 0; k < 12; k++) begin
            cmd.roll_in   = axis_pts[k];
            cmd.pitch_in  = axis_pts[(k + 4) % 12];
            cmd.yaw_in    = axis_pts[(k + 8) % 12];
            cmd.thrust_in = thr_pts[k % 6];
            queue_command(cmd);
        end
    endtask

    task automatic queue_random(input int count);
        rcss_pkg::in_t cmd;
        for (int k = 0; k < count; k++) begin
            cmd.roll_in   = rand_stick();
            cmd.pitch_in  = rand_stick();
            cmd.yaw_in    = rand_stick();
            cmd.thrust_in = rand_stick();
            queue_command(cmd);
        end
    endtask

    // Waits until every queued command has been transferred and every shaped
    // command checked, so the block is idle for register writes.
    task automatic wait_idle();
        while (items_accepted != items_queued || shaped_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_config();
        for (int idx = 0; idx < N_REGS; idx++)
            apb_write(idx, pick_cfg_value());
    endtask

    initial begin
        for (int idx = 0; idx < N_REGS; idx++)
            cfg_regs[idx] = 16'd0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        wait_idle();

        // Extremes: expo above, at and far above its clamp; superexpo of exactly one
        // zeroes roll. Writes beyond the last register must change nothing.
        apb_write(rcss_pkg::REG_EXPO_ROLL, rcss_pkg::ONE_Q15);
        apb_write(rcss_pkg::REG_EXPO_PITCH, 16'(rcss_pkg::EXPO_LIMIT));
        apb_write(rcss_pkg::REG_EXPO_YAW, 16'hFFFF);
        apb_write(rcss_pkg::REG_SUPER_ROLL, rcss_pkg::ONE_Q15);
        apb_write(rcss_pkg::REG_SUPER_PITCH, rcss_pkg::ONE_Q15 - 16'd1);
        apb_write(rcss_pkg::REG_SUPER_YAW, 16'hFFFF);
        for (int idx = SPARE_REG_FIRST; idx <= SPARE_REG_LAST; idx++)
            apb_write(idx, 16'h1234);
        queue_directed();
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            queue_random(ITEMS_PER_PHASE);
            wait_idle();
        end

        random_config();
        quiet_tail = 1'b1;
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
